@@ src/dqp_pkg.sv @@
// Package for the DNS question parser: parser phase and result kind codes,
// the input item and result structs, and default limits.
// No dependencies.
package dqp_pkg;

  // Default limits for the name and for one label
  localparam int unsigned MaxNameLenDefault  = 255;
  localparam int unsigned MaxLabelLenDefault = 63;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEN      = 3'd1,
    PH_LABEL    = 3'd2,
    PH_TYPE_HI  = 3'd3,
    PH_TYPE_LO  = 3'd4,
    PH_CLASS_HI = 3'd5,
    PH_CLASS_LO = 3'd6,
    PH_SKIP     = 3'd7
  } phase_e;

  // Result kind
  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_CHAR  = 3'd1,
    K_END   = 3'd2,
    K_TYPE  = 3'd3,
    K_CLASS = 3'd4,
    K_BAD   = 3'd5
  } kind_e;

  localparam logic [7:0] DotChar = 8'h2e;

  // One input byte with its side information
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_flag;
    logic [15:0] region_length;
  } item_t;

  // One result
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  name_char;
    logic [15:0] field_value;
    logic [8:0]  question_length;
  } result_t;

endpackage

@@ src/dqp_core.sv @@
// Parser state and per-byte step logic of the DNS question parser.
// Computes the result of one byte and updates the state when the byte moves on.
// Depends on dqp_pkg.
module dqp_core #(
  parameter int unsigned MAX_NAME_LEN  = dqp_pkg::MaxNameLenDefault,
  parameter int unsigned MAX_LABEL_LEN = dqp_pkg::MaxLabelLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqp_pkg::item_t    item_i,
  input  logic              step_i,
  output dqp_pkg::result_t  result_o
);
  import dqp_pkg::*;

  localparam logic [7:0] MaxLabel  = 8'(MAX_LABEL_LEN);
  localparam logic [8:0] MaxNameP1 = 9'(MAX_NAME_LEN + 1);

  phase_e      phase_q, phase_d;
  logic [5:0]  label_left_q, label_left_d;
  logic [8:0]  name_bytes_q, name_bytes_d;
  logic [15:0] region_q, region_d;
  logic [7:0]  high_q, high_d;

  // Effective state once a start byte has restarted the question
  phase_e      phase_eff;
  logic [5:0]  label_left_eff;
  logic [8:0]  name_bytes_eff;
  logic [15:0] region_eff;
  logic [8:0]  name_bytes_inc;
  logic [5:0]  label_left_dec;
  logic        len_bad;
  logic [7:0]  b;

  always_comb begin
    b = item_i.data_byte;
    if (item_i.start_flag) begin
      phase_eff      = PH_LEN;
      label_left_eff = '0;
      name_bytes_eff = '0;
      region_eff     = item_i.region_length;
    end else begin
      phase_eff      = phase_q;
      label_left_eff = label_left_q;
      name_bytes_eff = name_bytes_q;
      region_eff     = region_q;
    end
    name_bytes_inc = name_bytes_eff + 9'd1;
    label_left_dec = label_left_eff - 6'd1;
  end

  // Length byte checks; the first byte only gets the label check
  always_comb begin
    len_bad = (b > MaxLabel);
    if (name_bytes_eff != '0) begin
      if (name_bytes_eff > MaxNameP1) len_bad = 1'b1;
      if ((17'(name_bytes_eff) + 17'd3) > 17'(region_eff)) len_bad = 1'b1;
    end
  end

  // Next state
  always_comb begin
    phase_d      = phase_eff;
    label_left_d = label_left_eff;
    name_bytes_d = name_bytes_eff;
    region_d     = region_eff;
    high_d       = high_q;
    case (phase_eff)
      PH_LEN: begin
        if (len_bad) begin
          phase_d = PH_SKIP;
        end else if (b == 8'd0) begin
          phase_d      = PH_TYPE_HI;
          name_bytes_d = name_bytes_inc;
        end else begin
          label_left_d = b[5:0];
          phase_d      = PH_LABEL;
          name_bytes_d = name_bytes_inc;
        end
      end
      PH_LABEL: begin
        label_left_d = label_left_dec;
        if (label_left_dec == '0) phase_d = PH_LEN;
        name_bytes_d = name_bytes_inc;
      end
      PH_TYPE_HI: begin
        high_d       = b;
        phase_d      = PH_TYPE_LO;
        name_bytes_d = name_bytes_inc;
      end
      PH_TYPE_LO: begin
        phase_d      = PH_CLASS_HI;
        name_bytes_d = name_bytes_inc;
      end
      PH_CLASS_HI: begin
        high_d       = b;
        phase_d      = PH_CLASS_LO;
        name_bytes_d = name_bytes_inc;
      end
      PH_CLASS_LO: begin
        phase_d      = PH_IDLE;
        name_bytes_d = name_bytes_inc;
      end
      default: ;
    endcase
  end

  // Result of this byte
  always_comb begin
    result_o = '{kind: K_NONE, name_char: '0, field_value: '0, question_length: '0};
    case (phase_eff)
      PH_LEN: begin
        if (len_bad) begin
          result_o.kind = K_BAD;
        end else if (b == 8'd0) begin
          result_o.kind = K_END;
        end else if (name_bytes_eff != '0) begin
          result_o.kind      = K_CHAR;
          result_o.name_char = DotChar;
        end
      end
      PH_LABEL: begin
        result_o.kind      = K_CHAR;
        result_o.name_char = b;
      end
      PH_TYPE_LO: begin
        result_o.kind        = K_TYPE;
        result_o.field_value = {high_q, b};
      end
      PH_CLASS_LO: begin
        result_o.kind            = K_CLASS;
        result_o.field_value     = {high_q, b};
        result_o.question_length = name_bytes_inc;
      end
      default: ;
    endcase
  end

  // State registers, updated only when the byte moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      label_left_q <= '0;
      name_bytes_q <= '0;
      region_q     <= '0;
      high_q       <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      label_left_q <= label_left_d;
      name_bytes_q <= name_bytes_d;
      region_q     <= region_d;
      high_q       <= high_d;
    end
  end

endmodule

@@ src/dns_question_parser.sv @@
// DNS question parser: takes one question byte per transfer and gives one
// result per byte (name character or dot, name end, type, class with total
// length, malformed, or nothing). A byte passes an input register and a
// result register, so the block sustains one byte per clock; the only
// limit on rate is the consumer's stall. A stalled result holds while one
// more byte waits in the input register. Depends on dqp_pkg and dqp_core.
module dns_question_parser #(
  parameter int unsigned MAX_NAME_LEN  = dqp_pkg::MaxNameLenDefault,
  parameter int unsigned MAX_LABEL_LEN = dqp_pkg::MaxLabelLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_flag_i,
  input  logic [15:0] region_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  name_char_o,
  output logic [15:0] field_value_o,
  output logic [8:0]  question_length_o
);
  import dqp_pkg::*;

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  result_t result_c;
  logic    out_free;
  logic    step;
  logic    in_xfer;

  // Handshake: result stage frees when empty or taken, input stage moves on
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  dqp_core #(
    .MAX_NAME_LEN  (MAX_NAME_LEN),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_q),
    .step_i   (step),
    .result_o (result_c)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= '{data_byte: data_byte_i, start_flag: start_flag_i,
                  region_length: region_length_i};
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_c;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = result_q.kind;
  assign name_char_o       = result_q.name_char;
  assign field_value_o     = result_q.field_value;
  assign question_length_o = result_q.question_length;

endmodule
